// ===== hdl/bls_pkg.sv =====
// shared types and constants for the bresenham line stepper
// no dependencies; imported by every module of the block
`default_nettype none

package bls_pkg;

    localparam int COORD_BITS  = 6;
    localparam int COLOR_BITS  = 32;
    // error accumulator and its sum span (-delta, 3*delta], plus sign
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic [COORD_BITS:0]        t_delta2;
    typedef logic signed [ERR_BITS-1:0] t_err;
    typedef logic [COLOR_BITS-1:0]      t_color;
    typedef logic [QPTR_BITS-1:0]       t_qptr;
    typedef logic [QPTR_BITS:0]         t_qcount;

    // one classified line, ready to be stepped
    typedef struct packed {
        t_coord  major_pos;
        t_coord  major_stop;
        t_coord  minor_pos;
        t_coord  major_delta;
        t_delta2 minor_delta2;
        logic    step_down;
        logic    transposed;
        t_color  color;
    } t_cmd;

    // queue status seen by its neighbors
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_qstat;

endpackage

`default_nettype wire

// ===== hdl/bls_front.sv =====
// front end: accepts a segment, transposes steep lines, orders endpoints
// depends on bls_pkg; feeds bls_queue
`default_nettype none

module bls_front
    import bls_pkg::*;
(
    input  wire logic   i_in_valid,
    output logic        o_in_ready,
    input  wire t_coord i_x_start,
    input  wire t_coord i_y_start,
    input  wire t_coord i_x_end,
    input  wire t_coord i_y_end,
    input  wire t_color i_pixel_color,
    input  wire t_qstat i_qstat,
    output logic        o_push,
    output t_cmd        o_cmd
);

    t_coord s_dx;
    t_coord s_dy;
    logic   s_steep;
    t_coord s_a0, s_b0, s_a1, s_b1;
    t_coord s_lo_a, s_lo_b, s_hi_a, s_hi_b;
    t_coord s_minor_delta;

    always_comb begin
        s_dx    = (i_x_start > i_x_end) ? i_x_start - i_x_end : i_x_end - i_x_start;
        s_dy    = (i_y_start > i_y_end) ? i_y_start - i_y_end : i_y_end - i_y_start;
        s_steep = s_dx < s_dy;

        if (s_steep) begin
            s_a0 = i_y_start; s_b0 = i_x_start; s_a1 = i_y_end; s_b1 = i_x_end;
        end else begin
            s_a0 = i_x_start; s_b0 = i_y_start; s_a1 = i_x_end; s_b1 = i_y_end;
        end

        // major coordinate must increase
        if (s_a0 > s_a1) begin
            s_lo_a = s_a1; s_lo_b = s_b1; s_hi_a = s_a0; s_hi_b = s_b0;
        end else begin
            s_lo_a = s_a0; s_lo_b = s_b0; s_hi_a = s_a1; s_hi_b = s_b1;
        end

        s_minor_delta = (s_lo_b > s_hi_b) ? s_lo_b - s_hi_b : s_hi_b - s_lo_b;

        o_cmd.major_pos    = s_lo_a;
        o_cmd.major_stop   = s_hi_a;
        o_cmd.minor_pos    = s_lo_b;
        o_cmd.major_delta  = s_hi_a - s_lo_a;
        o_cmd.minor_delta2 = {s_minor_delta, 1'b0};
        o_cmd.step_down    = s_hi_b < s_lo_b;
        o_cmd.transposed   = s_steep;
        o_cmd.color        = i_pixel_color;
    end

    assign o_in_ready = !i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full;

endmodule

`default_nettype wire

// ===== hdl/bls_queue.sv =====
// short command queue between the front end and the stepper
// depends on bls_pkg
`default_nettype none

module bls_queue
    import bls_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output t_qstat    o_qstat
);

    t_cmd    r_mem [QUEUE_DEPTH];
    t_qptr   r_wr_ptr;
    t_qptr   r_rd_ptr;
    t_qcount r_count;

    logic s_push;
    logic s_pop;

    assign s_push = i_push && !o_qstat.full;
    assign s_pop  = i_pop && o_qstat.not_empty;

    always_comb begin
        o_qstat.full      = r_count == t_qcount'(QUEUE_DEPTH);
        o_qstat.not_empty = r_count != '0;
        o_cmd             = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (s_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (s_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({s_push, s_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_qcount'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // pointers differ by the occupancy, modulo the queue depth
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_qptr'(r_wr_ptr - r_rd_ptr) == t_qptr'(r_count))
        else $error("queue pointers out of step with count");

    // a pop on an empty queue is ignored, count holds
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_qstat.not_empty && !i_push) |=> (r_count == '0))
        else $error("count moved on empty queue");

endmodule

`default_nettype wire

// ===== hdl/bls_stepper.sv =====
// back end: steps one queued line a pixel per cycle, while the output is not stalled, into an output register
// depends on bls_pkg; drains bls_queue
`default_nettype none

module bls_stepper
    import bls_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_qstat i_qstat,
    input  wire t_cmd   i_cmd,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output t_coord      o_pixel_x,
    output t_coord      o_pixel_y,
    output t_color      o_out_color,
    output logic        o_last_pixel
);

    logic    r_busy;
    t_coord  r_major_pos;
    t_coord  r_major_stop;
    t_coord  r_minor_pos;
    t_coord  r_major_delta;
    t_delta2 r_minor_delta2;
    logic    r_step_down;
    logic    r_transposed;
    t_color  r_held_color;
    t_err    r_err;

    logic    r_out_valid;
    t_coord  r_pixel_x;
    t_coord  r_pixel_y;
    t_color  r_out_color;
    logic    r_last_pixel;

    logic    s_step;
    logic    s_last;
    t_err    s_delta_ext;
    t_err    s_err_sum;
    logic    s_minor_move;

    always_comb begin
        o_pop        = !r_busy && i_qstat.not_empty;
        s_step       = r_busy && (!r_out_valid || i_out_ready);
        s_last       = r_major_pos == r_major_stop;
        s_delta_ext  = $signed({3'b000, r_major_delta});
        s_err_sum    = r_err + $signed({2'b00, r_minor_delta2});
        s_minor_move = s_err_sum > s_delta_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (s_step && s_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_major_pos    <= i_cmd.major_pos;
            r_major_stop   <= i_cmd.major_stop;
            r_minor_pos    <= i_cmd.minor_pos;
            r_major_delta  <= i_cmd.major_delta;
            r_minor_delta2 <= i_cmd.minor_delta2;
            r_step_down    <= i_cmd.step_down;
            r_transposed   <= i_cmd.transposed;
            r_held_color   <= i_cmd.color;
            r_err          <= '0;
        end else if (s_step) begin
            if (s_minor_move) begin
                r_minor_pos <= r_step_down ? r_minor_pos - 1'b1 : r_minor_pos + 1'b1;
                r_err       <= s_err_sum - $signed({2'b00, r_major_delta, 1'b0});
            end else begin
                r_err       <= s_err_sum;
            end
            if (!s_last) begin
                r_major_pos <= r_major_pos + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_step) begin
            r_pixel_x    <= r_transposed ? r_minor_pos : r_major_pos;
            r_pixel_y    <= r_transposed ? r_major_pos : r_minor_pos;
            r_out_color  <= r_held_color;
            r_last_pixel <= s_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_pixel_x;
    assign o_pixel_y    = r_pixel_y;
    assign o_out_color  = r_out_color;
    assign o_last_pixel = r_last_pixel;

    // stepping never runs past the far endpoint
    a_major_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_major_pos <= r_major_stop))
        else $error("major position past stop");

    // error term stays within one major delta of zero between steps
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_err <= s_delta_ext) && (r_err >= -s_delta_ext)))
        else $error("error accumulator out of range");

    // the last pixel of a line frees the stepper
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_step && s_last) |=> (!r_busy && r_out_valid && r_last_pixel))
        else $error("stepper still busy after last pixel");

    // no new line is taken while one is in progress
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_pop)
        else $error("pop while busy");

endmodule

`default_nettype wire

// ===== hdl/bresenham_line_stepper.sv =====
// path: when idle, a segment's first pixel passes the queue, the stepper's load
// and the output register; throughput: each line is loaded once, then stepped one
// pixel per cycle, up to 64 pixels for the lines of a 6-bit grid; the stepper's
// single-pixel-per-cycle loop sets the rate while the output is not stalled; a
// 2-deep queue lets the front accept new segments while a line is still being stepped
// reset: synchronous active-low, clears queue, stepper busy flag and output valid
`default_nettype none

module bresenham_line_stepper
    import bls_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    // segment channel
    input  wire logic   i_in_valid,
    output logic        o_in_ready,
    input  wire t_coord i_x_start,
    input  wire t_coord i_y_start,
    input  wire t_coord i_x_end,
    input  wire t_coord i_y_end,
    input  wire t_color i_pixel_color,
    // pixel channel
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output t_coord      o_pixel_x,
    output t_coord      o_pixel_y,
    output t_color      o_out_color,
    output logic        o_last_pixel
);

    // front to queue
    logic   s_push;
    t_cmd   s_push_cmd;
    // queue to stepper
    t_qstat s_qstat;
    t_cmd   s_head_cmd;
    logic   s_pop;

    // classify the segment: steep lines transposed, endpoints ordered
    bls_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_pixel_color (i_pixel_color),
        .i_qstat       (s_qstat),
        .o_push        (s_push),
        .o_cmd         (s_push_cmd)
    );

    // decouples segment acceptance from pixel stepping
    bls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_cmd   (s_push_cmd),
        .i_pop   (s_pop),
        .o_cmd   (s_head_cmd),
        .o_qstat (s_qstat)
    );

    // one pixel per cycle into a registered output that can stall on its own
    bls_stepper u_stepper (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qstat      (s_qstat),
        .i_cmd        (s_head_cmd),
        .o_pop        (s_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_out_color  (o_out_color),
        .o_last_pixel (o_last_pixel)
    );

endmodule

`default_nettype wire
